FILE: rtl/i2c_master_transfer_sequencer_core_assert.svh
// ----------------------------------------------------------------------------
// I2C transfer sequencer assertion macros
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define I2CTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/i2cts_pkg.sv
// ----------------------------------------------------------------------------
// i2cts_pkg
// Types and codes shared by the I2C transfer sequencer modules.
// ----------------------------------------------------------------------------
package i2cts_pkg;

  typedef enum logic [2:0] {
    CMD_START_READ  = 3'd0,
    CMD_START_WRITE = 3'd1,
    CMD_BYTE_RX     = 3'd2,
    CMD_TX_READY    = 3'd3,
    CMD_ARB_LOST    = 3'd4,
    CMD_NACK        = 3'd5,
    CMD_UNHANDLED   = 3'd6,
    CMD_TICK        = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_BUSY    = 3'd1,
    ST_OK      = 3'd2,
    ST_ARB     = 3'd3,
    ST_NACK    = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_STORE = 2'd1,
    ACT_SEND  = 2'd2
  } byte_action_t;

  typedef enum logic [1:0] {
    START_NONE = 2'd0,
    START_RX   = 2'd1,
    START_TX   = 2'd2
  } start_t;

  typedef enum logic [1:0] {
    STOP_NONE   = 2'd0,
    STOP_REQ    = 2'd1,
    STOP_CANCEL = 2'd2
  } stop_t;

  localparam logic [15:0] MIN_READ_BYTES  = 16'd2;
  localparam logic [15:0] DEFAULT_TIMEOUT = 16'd35;
  localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [6:0]  slave_address;
    logic [15:0] byte_count;
    logic [7:0]  rx_data;
    logic [7:0]  tx_data;
    logic        bus_busy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  byte_action;
    logic [7:0]  bus_byte;
    logic [15:0] buffer_index;
    logic [1:0]  start_request;
    logic [6:0]  target_address;
    logic [1:0]  stop_request;
    logic        recovery_request;
    logic [15:0] error_count;
    logic [15:0] nack_count;
    logic [15:0] arb_loss_count;
    logic [15:0] unhandled_count;
  } result_t;

  // Handshake state of the input register toward the result register.
  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

endpackage

FILE: rtl/i2cts_ifs.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer channels
// Valid/ready channels for event input, results and the timeout register.
// ----------------------------------------------------------------------------
interface i2cts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [6:0]  slave_address;
  logic [15:0] byte_count;
  logic [7:0]  rx_data;
  logic [7:0]  tx_data;
  logic        bus_busy;

  modport source (output valid, cmd, slave_address, byte_count, rx_data, tx_data,
                  bus_busy, input ready);
  modport sink (input valid, cmd, slave_address, byte_count, rx_data, tx_data,
                bus_busy, output ready);
endinterface

interface i2cts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  byte_action;
  logic [7:0]  bus_byte;
  logic [15:0] buffer_index;
  logic [1:0]  start_request;
  logic [6:0]  target_address;
  logic [1:0]  stop_request;
  logic        recovery_request;
  logic [15:0] error_count;
  logic [15:0] nack_count;
  logic [15:0] arb_loss_count;
  logic [15:0] unhandled_count;

  modport source (output valid, status, byte_action, bus_byte, buffer_index,
                  start_request, target_address, stop_request, recovery_request,
                  error_count, nack_count, arb_loss_count, unhandled_count,
                  input ready);
  modport sink (input valid, status, byte_action, bus_byte, buffer_index,
                start_request, target_address, stop_request, recovery_request,
                error_count, nack_count, arb_loss_count, unhandled_count,
                output ready);
endinterface

interface i2cts_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, timeout_ticks, input ready);
  modport sink (input valid, timeout_ticks, output ready);
endinterface

FILE: rtl/i2cts_in_stage.sv
// ----------------------------------------------------------------------------
// i2cts_in_stage
// Input register: captures one event beat and holds it until it moves on.
// ----------------------------------------------------------------------------
module i2cts_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2cts_pkg::in_item_t in_item,
  input  logic               take,
  output i2cts_pkg::pipe_ctl_t ctl,
  output i2cts_pkg::in_item_t item
);
  import i2cts_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_ready    = !valid_r || take;
  assign load        = in_valid && in_ready;
  assign valid_nxt   = load || (valid_r && !take);
  assign ctl.valid   = valid_r;
  assign ctl.advance = valid_r && take;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: rtl/i2cts_seq_core.sv
// ----------------------------------------------------------------------------
// i2cts_seq_core
// Transfer state, error counters and the result of one event.
// ----------------------------------------------------------------------------
module i2cts_seq_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cts_pkg::pipe_ctl_t ctl,
  input  i2cts_pkg::in_item_t  item,
  input  logic [15:0]          timeout_ticks,
  output i2cts_pkg::result_t   result,
  output i2cts_pkg::mode_t     mode,
  output i2cts_pkg::status_t   status,
  output logic [15:0]          remaining,
  output logic [15:0]          total_errors
);
  import i2cts_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  mode_t                  mode_r, mode_nxt;
  status_t                status_r, status_nxt;
  logic [15:0]            remain_r, remain_nxt;
  logic [15:0]            pos_r, pos_nxt;
  logic [15:0]            ticks_r, ticks_nxt;
  logic [COUNT_WIDTH-1:0] tot_r, tot_nxt;
  logic [COUNT_WIDTH-1:0] nack_r, nack_nxt;
  logic [COUNT_WIDTH-1:0] arb_r, arb_nxt;
  logic [COUNT_WIDTH-1:0] unh_r, unh_nxt;

  cmd_t        cmd;
  logic [15:0] ticks_inc;
  logic        timed_out;
  logic        failed_read;
  logic [1:0]  tot_inc;
  logic        recover;

  logic [COUNT_WIDTH+15:0] tot_ext, nack_ext, arb_ext, unh_ext;
  logic [COUNT_WIDTH+15:0] tot_cur_ext;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] c,
                                                    input logic [1:0] inc);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, c} + {{(COUNT_WIDTH-1){1'b0}}, inc};
    if (s > {1'b0, CNT_MAX}) begin
      sat_add = CNT_MAX;
    end else begin
      sat_add = s[COUNT_WIDTH-1:0];
    end
  endfunction

  assign cmd         = cmd_t'(item.cmd);
  assign ticks_inc   = (ticks_r < TICKS_MAX) ? ticks_r + 16'd1 : ticks_r;
  assign timed_out   = (status_r == ST_BUSY) && (ticks_inc >= timeout_ticks);
  assign failed_read = (mode_r == MODE_READ) && (status_r == ST_BUSY);

  // Recovery is asked for on a busy bus at a start and when a read fails.
  always_comb begin
    case (cmd)
      CMD_START_READ, CMD_START_WRITE: recover = item.bus_busy;
      CMD_ARB_LOST, CMD_NACK:          recover = failed_read;
      CMD_TICK:                        recover = timed_out && (mode_r == MODE_READ);
      default:                         recover = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    mode_nxt   = mode_r;
    status_nxt = status_r;
    remain_nxt = remain_r;
    pos_nxt    = pos_r;
    ticks_nxt  = ticks_r;
    nack_nxt   = nack_r;
    arb_nxt    = arb_r;
    unh_nxt    = unh_r;
    tot_inc    = {1'b0, recover};
    case (cmd)
      CMD_START_READ, CMD_START_WRITE: begin
        if (cmd == CMD_START_READ) begin
          mode_nxt   = MODE_READ;
          remain_nxt = (item.byte_count < MIN_READ_BYTES) ? MIN_READ_BYTES
                                                          : item.byte_count;
        end else begin
          mode_nxt   = MODE_WRITE;
          remain_nxt = item.byte_count;
        end
        pos_nxt    = 16'd0;
        ticks_nxt  = 16'd0;
        status_nxt = ST_BUSY;
      end
      CMD_BYTE_RX: begin
        if (mode_r == MODE_READ && remain_r > 16'd1) begin
          remain_nxt = remain_r - 16'd1;
          pos_nxt    = pos_r + 16'd1;
        end else if (mode_r == MODE_READ && remain_r == 16'd1) begin
          remain_nxt = 16'd0;
          status_nxt = ST_OK;
          mode_nxt   = MODE_IDLE;
        end
      end
      CMD_TX_READY: begin
        if (mode_r == MODE_WRITE) begin
          if (remain_r != 16'd0) begin
            pos_nxt    = pos_r + 16'd1;
            remain_nxt = remain_r - 16'd1;
          end else begin
            status_nxt = ST_OK;
            mode_nxt   = MODE_IDLE;
          end
        end
      end
      CMD_ARB_LOST: begin
        arb_nxt    = sat_add(arb_r, 2'd1);
        status_nxt = ST_ARB;
        mode_nxt   = MODE_IDLE;
        tot_inc    = 2'd1 + {1'b0, recover};
      end
      CMD_NACK: begin
        nack_nxt   = sat_add(nack_r, 2'd1);
        status_nxt = ST_NACK;
        mode_nxt   = MODE_IDLE;
        tot_inc    = 2'd1 + {1'b0, recover};
      end
      CMD_UNHANDLED: begin
        unh_nxt = sat_add(unh_r, 2'd1);
        tot_inc = 2'd1;
      end
      CMD_TICK: begin
        if (status_r == ST_BUSY) begin
          ticks_nxt = ticks_inc;
          if (timed_out) begin
            status_nxt = ST_TIMEOUT;
            mode_nxt   = MODE_IDLE;
          end
        end
      end
      default: begin
        tot_inc = 2'd0;
      end
    endcase
    tot_nxt = sat_add(tot_r, tot_inc);
  end

  assign tot_ext  = {16'd0, tot_nxt};
  assign nack_ext = {16'd0, nack_nxt};
  assign arb_ext  = {16'd0, arb_nxt};
  assign unh_ext  = {16'd0, unh_nxt};

  // Result fields.
  always_comb begin
    result                  = '0;
    result.status           = status_nxt;
    result.recovery_request = recover;
    result.error_count      = tot_ext[15:0];
    result.nack_count       = nack_ext[15:0];
    result.arb_loss_count   = arb_ext[15:0];
    result.unhandled_count  = unh_ext[15:0];
    case (cmd)
      CMD_START_READ, CMD_START_WRITE: begin
        result.start_request  = (cmd == CMD_START_READ) ? START_RX : START_TX;
        result.target_address = item.slave_address;
      end
      CMD_BYTE_RX: begin
        if (mode_r == MODE_READ && remain_r != 16'd0) begin
          result.byte_action  = ACT_STORE;
          result.bus_byte     = item.rx_data;
          result.buffer_index = pos_r;
          // Stop goes out with the byte that leaves exactly one to read.
          if (remain_r == 16'd2) begin
            result.stop_request = STOP_REQ;
          end
        end else begin
          result.stop_request = STOP_REQ;
        end
      end
      CMD_TX_READY: begin
        if (mode_r == MODE_WRITE) begin
          if (remain_r != 16'd0) begin
            result.byte_action  = ACT_SEND;
            result.bus_byte     = item.tx_data;
            result.buffer_index = pos_r;
          end else begin
            result.stop_request = STOP_REQ;
          end
        end
      end
      CMD_ARB_LOST: begin
        result.stop_request = STOP_CANCEL;
      end
      CMD_NACK: begin
        result.stop_request = STOP_REQ;
      end
      default: begin
        result.stop_request = STOP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      status_r <= ST_IDLE;
      remain_r <= 16'd0;
      pos_r    <= 16'd0;
      ticks_r  <= 16'd0;
      tot_r    <= '0;
      nack_r   <= '0;
      arb_r    <= '0;
      unh_r    <= '0;
    end else if (ctl.advance) begin
      mode_r   <= mode_nxt;
      status_r <= status_nxt;
      remain_r <= remain_nxt;
      pos_r    <= pos_nxt;
      ticks_r  <= ticks_nxt;
      tot_r    <= tot_nxt;
      nack_r   <= nack_nxt;
      arb_r    <= arb_nxt;
      unh_r    <= unh_nxt;
    end
  end

  assign mode         = mode_r;
  assign status       = status_r;
  assign remaining    = remain_r;
  assign tot_cur_ext  = {16'd0, tot_r};
  assign total_errors = tot_cur_ext[15:0];

endmodule

FILE: rtl/i2cts_out_stage.sv
// ----------------------------------------------------------------------------
// i2cts_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module i2cts_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cts_pkg::pipe_ctl_t ctl,
  input  i2cts_pkg::result_t   result,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cts_pkg::result_t   out_result
);
  import i2cts_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign can_load   = !valid_r || out_ready;
  assign valid_nxt  = ctl.advance || (valid_r && !out_ready);
  assign out_valid  = valid_r;
  assign out_result = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      data_r <= result;
    end
  end

endmodule

FILE: rtl/i2c_master_transfer_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// An event beat passes through the input register and then the result register
// before its result beat can be taken. Throughput: one event per cycle, set by
// the input and result registers, while the result side does not stall.
// Reset (rst_n low, synchronous): idle, counters zero, timeout set to 35.
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_core_assert.svh"

module i2c_master_transfer_sequencer_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  i2cts_in_if.sink     in_ch,
  i2cts_out_if.source  out_ch,
  i2cts_cfg_if.sink    cfg_ch
);
  import i2cts_pkg::*;

  logic [15:0] timeout_r;
  in_item_t    in_item;
  in_item_t    item;
  pipe_ctl_t   ctl;
  logic        can_load;
  result_t     result;
  result_t     out_result;
  mode_t       mode;
  status_t     status;
  logic [15:0] remaining;
  logic [15:0] total_errors;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= DEFAULT_TIMEOUT;
    end else if (cfg_ch.valid) begin
      timeout_r <= cfg_ch.timeout_ticks;
    end
  end

  assign in_item.cmd           = in_ch.cmd;
  assign in_item.slave_address = in_ch.slave_address;
  assign in_item.byte_count    = in_ch.byte_count;
  assign in_item.rx_data       = in_ch.rx_data;
  assign in_item.tx_data       = in_ch.tx_data;
  assign in_item.bus_busy      = in_ch.bus_busy;

  i2cts_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .take     (can_load),
    .ctl      (ctl),
    .item     (item)
  );

  i2cts_seq_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .item          (item),
    .timeout_ticks (timeout_r),
    .result        (result),
    .mode          (mode),
    .status        (status),
    .remaining     (remaining),
    .total_errors  (total_errors)
  );

  i2cts_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  assign out_ch.status           = out_result.status;
  assign out_ch.byte_action      = out_result.byte_action;
  assign out_ch.bus_byte         = out_result.bus_byte;
  assign out_ch.buffer_index     = out_result.buffer_index;
  assign out_ch.start_request    = out_result.start_request;
  assign out_ch.target_address   = out_result.target_address;
  assign out_ch.stop_request     = out_result.stop_request;
  assign out_ch.recovery_request = out_result.recovery_request;
  assign out_ch.error_count      = out_result.error_count;
  assign out_ch.nack_count       = out_result.nack_count;
  assign out_ch.arb_loss_count   = out_result.arb_loss_count;
  assign out_ch.unhandled_count  = out_result.unhandled_count;

  // A transfer is active exactly while the status reads in progress.
  `I2CTS_ASSERT_NOW(a_mode_status, 1'b1, (mode != MODE_IDLE) == (status == ST_BUSY), "mode and status disagree")
  // A read in progress always has at least one byte left.
  `I2CTS_ASSERT_NOW(a_read_remaining, mode == MODE_READ, remaining != 16'd0, "read with no bytes left")
  // A held event beat means the result register is full and stalled.
  `I2CTS_ASSERT_NOW(a_stall_cause, ctl.valid && !ctl.advance, out_ch.valid && !out_ch.ready, "event held without a stall")
  // The total error counter never goes down.
  `I2CTS_ASSERT_NEXT(a_errors_grow, 1'b1, total_errors >= $past(total_errors), "error count decreased")

endmodule

FILE: tb/sv/i2c_master_transfer_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for i2c_master_transfer_sequencer_core
// Feeds bus events through the valid/ready event channel and checks every
// result beat, in order, against a cycle-free model of the transfer sequencer.
// The run covers directed corner cases and random transfers under several
// timeout settings up to the longest one, with random gaps on the event side
// and random stalls on the result side.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core_tb;
  import i2cts_pkg::*;

  localparam int          CYCLE_LIMIT       = 5000000;
  localparam int          LONG_STALL_CYCLES = 400;
  localparam int          MAX_REPORTS       = 200;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

  typedef struct {
    in_item_t ev;
    bit       typed;
    result_t  want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  i2cts_in_if  in_if ();
  i2cts_out_if out_if ();
  i2cts_cfg_if cfg_if ();

  i2c_master_transfer_sequencer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Model state of the sequencer.
  mode_t       cur_mode;
  status_t     cur_status;
  logic [15:0] left_bytes;
  logic [15:0] next_pos;
  logic [15:0] tick_count;
  logic [15:0] timeout_limit;
  logic [15:0] err_total;
  logic [15:0] err_nack;
  logic [15:0] err_arb;
  logic [15:0] evt_unhandled;

  result_t pending_actions[$];

  int  events_sent;
  int  beats_checked;
  int  mismatches;
  int  timeout_writes;
  int  burst_left;
  int  cycle_count;
  bit  long_stall_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == COUNT_MAX) ? c : c + 16'd1;
  endfunction

  // Applies one event to the model state and returns the result beat it causes.
  function automatic result_t transfer_step(input in_item_t ev);
    result_t r;
    logic    failed_read;
    r = '0;
    case (cmd_t'(ev.cmd))
      CMD_START_READ, CMD_START_WRITE: begin
        if (ev.bus_busy) begin
          r.recovery_request = 1'b1;
          err_total = sat_inc(err_total);
        end
        if (ev.cmd == CMD_START_READ) begin
          cur_mode = MODE_READ;
          left_bytes = (ev.byte_count < MIN_READ_BYTES) ? MIN_READ_BYTES : ev.byte_count;
          r.start_request = START_RX;
        end else begin
          cur_mode = MODE_WRITE;
          left_bytes = ev.byte_count;
          r.start_request = START_TX;
        end
        r.target_address = ev.slave_address;
        next_pos = '0;
        tick_count = '0;
        cur_status = ST_BUSY;
      end
      CMD_BYTE_RX: begin
        if (cur_mode == MODE_READ && left_bytes > 16'd1) begin
          left_bytes = left_bytes - 16'd1;
          r.byte_action = ACT_STORE;
          r.bus_byte = ev.rx_data;
          r.buffer_index = next_pos;
          next_pos = next_pos + 16'd1;
          // STOP goes out while the last byte is still on the wire.
          if (left_bytes == 16'd1) r.stop_request = STOP_REQ;
        end else if (cur_mode == MODE_READ && left_bytes == 16'd1) begin
          left_bytes = '0;
          r.byte_action = ACT_STORE;
          r.bus_byte = ev.rx_data;
          r.buffer_index = next_pos;
          cur_status = ST_OK;
          cur_mode = MODE_IDLE;
        end else begin
          r.stop_request = STOP_REQ;
        end
      end
      CMD_TX_READY: begin
        if (cur_mode == MODE_WRITE) begin
          if (left_bytes != 16'd0) begin
            r.byte_action = ACT_SEND;
            r.bus_byte = ev.tx_data;
            r.buffer_index = next_pos;
            next_pos = next_pos + 16'd1;
            left_bytes = left_bytes - 16'd1;
          end else begin
            r.stop_request = STOP_REQ;
            cur_status = ST_OK;
            cur_mode = MODE_IDLE;
          end
        end
      end
      CMD_ARB_LOST, CMD_NACK: begin
        failed_read = (cur_mode == MODE_READ && cur_status == ST_BUSY);
        if (ev.cmd == CMD_ARB_LOST) begin
          r.stop_request = STOP_CANCEL;
          err_arb = sat_inc(err_arb);
          cur_status = ST_ARB;
        end else begin
          r.stop_request = STOP_REQ;
          err_nack = sat_inc(err_nack);
          cur_status = ST_NACK;
        end
        err_total = sat_inc(err_total);
        if (failed_read) begin
          r.recovery_request = 1'b1;
          err_total = sat_inc(err_total);
        end
        cur_mode = MODE_IDLE;
      end
      CMD_UNHANDLED: begin
        evt_unhandled = sat_inc(evt_unhandled);
        err_total = sat_inc(err_total);
      end
      default: begin
        if (cur_status == ST_BUSY) begin
          if (tick_count != TICKS_MAX) tick_count = tick_count + 16'd1;
          if (tick_count >= timeout_limit) begin
            if (cur_mode == MODE_READ) begin
              r.recovery_request = 1'b1;
              err_total = sat_inc(err_total);
            end
            cur_status = ST_TIMEOUT;
            cur_mode = MODE_IDLE;
          end
        end
      end
    endcase
    r.status = cur_status;
    r.error_count = err_total;
    r.nack_count = err_nack;
    r.arb_loss_count = err_arb;
    r.unhandled_count = evt_unhandled;
    return r;
  endfunction

  function automatic in_item_t mk_event(input cmd_t c, input logic [6:0] a,
                                        input logic [15:0] n, input logic [7:0] rx,
                                        input logic [7:0] tx, input logic b);
    in_item_t ev;
    ev.cmd = c;
    ev.slave_address = a;
    ev.byte_count = n;
    ev.rx_data = rx;
    ev.tx_data = tx;
    ev.bus_busy = b;
    return ev;
  endfunction

  function automatic result_t mk_result(input status_t s, input stop_t sp,
                                        input logic [15:0] e, input logic [15:0] nk,
                                        input logic [15:0] ab, input logic [15:0] un);
    result_t r;
    r = '0;
    r.status = s;
    r.stop_request = sp;
    r.error_count = e;
    r.nack_count = nk;
    r.arb_loss_count = ab;
    r.unhandled_count = un;
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t ev;
    ev.cmd = 3'($urandom_range(0, 7));
    ev.slave_address = 7'($urandom_range(0, 127));
    ev.byte_count = 16'($urandom_range(0, 65535));
    ev.rx_data = 8'($urandom_range(0, 255));
    ev.tx_data = 8'($urandom_range(0, 255));
    ev.bus_busy = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Offers one event beat and waits until it is taken; then maybe opens a gap.
  task automatic drive_event(input in_item_t ev, input bit typed = 1'b0,
                             input result_t want = '0);
    result_t r;
    in_if.valid <= 1'b1;
    in_if.cmd <= ev.cmd;
    in_if.slave_address <= ev.slave_address;
    in_if.byte_count <= ev.byte_count;
    in_if.rx_data <= ev.rx_data;
    in_if.tx_data <= ev.tx_data;
    in_if.bus_busy <= ev.bus_busy;
    do @(posedge clk); while (!in_if.ready);
    r = transfer_step(ev);
    pending_actions.push_back(typed ? want : r);
    events_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
    end
  endtask

  // Lowers valid and waits until every pending result beat has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_actions.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    cfg_if.valid <= 1'b1;
    cfg_if.timeout_ticks <= ticks;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    timeout_limit = ticks;
    timeout_writes++;
  endtask

  // Mostly well-formed transfers with random content, plus stray events.
  task automatic random_transfers(input int n_items);
    int       stop_at;
    int       len;
    int       k;
    int       r;
    bit       is_read;
    in_item_t ev;
    stop_at = events_sent + n_items;
    while (events_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        drive_event(random_item());
      end else begin
        is_read = 1'($urandom_range(0, 1));
        ev = random_item();
        ev.cmd = is_read ? CMD_START_READ : CMD_START_WRITE;
        if ($urandom_range(0, 7) != 0) ev.byte_count = 16'($urandom_range(0, 6));
        ev.bus_busy = ($urandom_range(0, 5) == 0);
        len = (ev.byte_count > 16'd10) ? 10 : int'(ev.byte_count);
        if (is_read && len < 2) len = 2;
        len = len + $urandom_range(0, 2);
        drive_event(ev);
        // Now and then let the transfer run into its timeout.
        if (timeout_limit <= 16'd64 && $urandom_range(0, 5) == 0) begin
          repeat (timeout_limit) begin
            ev = random_item();
            ev.cmd = CMD_TICK;
            drive_event(ev);
          end
        end
        for (k = 0; k < len; k++) begin
          ev = random_item();
          r = $urandom_range(0, 15);
          if (r < 11) ev.cmd = is_read ? CMD_BYTE_RX : CMD_TX_READY;
          else if (r < 14) ev.cmd = CMD_TICK;
          else if (r == 14) ev.cmd = $urandom_range(0, 1) ? CMD_ARB_LOST : CMD_NACK;
          drive_event(ev);
        end
      end
    end
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      // Reporting is capped so a broken block cannot flood the log.
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.status, out_if.byte_action, out_if.bus_byte, out_if.buffer_index,
             out_if.start_request, out_if.target_address, out_if.stop_request,
             out_if.recovery_request, out_if.error_count, out_if.nack_count,
             out_if.arb_loss_count, out_if.unhandled_count};
      if (pending_actions.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing pending, expected none, actual %h",
                 $time, got);
      end else begin
        want = pending_actions.pop_front();
        beats_checked++;
        check_field("status", want.status, got.status);
        check_field("byte_action", want.byte_action, got.byte_action);
        check_field("bus_byte", want.bus_byte, got.bus_byte);
        check_field("buffer_index", want.buffer_index, got.buffer_index);
        check_field("start_request", want.start_request, got.start_request);
        check_field("target_address", want.target_address, got.target_address);
        check_field("stop_request", want.stop_request, got.stop_request);
        check_field("recovery_request", want.recovery_request, got.recovery_request);
        check_field("error_count", want.error_count, got.error_count);
        check_field("nack_count", want.nack_count, got.nack_count);
        check_field("arb_loss_count", want.arb_loss_count, got.arb_loss_count);
        check_field("unhandled_count", want.unhandled_count, got.unhandled_count);
      end
    end
  end

  // The result side stalls in short random runs, with the odd stall-free
  // stretch and one long hold-off that backs the block up into its input.
  initial begin : result_receiver
    int run_len;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 15))
          0: begin
            out_if.ready <= 1'b1;
            run_len = 200;
          end
          1, 2, 3, 4: begin
            out_if.ready <= 1'b0;
            run_len = $urandom_range(1, 4);
          end
          default: begin
            out_if.ready <= 1'b1;
            run_len = $urandom_range(1, 12);
          end
        endcase
        repeat (run_len - 1) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows[$];
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.cmd <= CMD_TICK;
    in_if.slave_address <= '0;
    in_if.byte_count <= '0;
    in_if.rx_data <= '0;
    in_if.tx_data <= '0;
    in_if.bus_busy <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.timeout_ticks <= DEFAULT_TIMEOUT;
    cur_mode = MODE_IDLE;
    cur_status = ST_IDLE;
    left_bytes = '0;
    next_pos = '0;
    tick_count = '0;
    timeout_limit = DEFAULT_TIMEOUT;
    err_total = '0;
    err_nack = '0;
    err_arb = '0;
    evt_unhandled = '0;
    burst_left = $urandom_range(1, 16);

    // Idle-state events first, where the whole result is known by hand.
    dir_rows.push_back('{mk_event(CMD_TICK, 7'd0, 16'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_result(ST_IDLE, STOP_NONE, 16'd0, 16'd0, 16'd0, 16'd0)});
    dir_rows.push_back('{mk_event(CMD_UNHANDLED, 7'd127, 16'hFFFF, 8'hFF, 8'hFF, 1'b1),
                         1'b1, mk_result(ST_IDLE, STOP_NONE, 16'd1, 16'd0, 16'd0, 16'd1)});
    dir_rows.push_back('{mk_event(CMD_ARB_LOST, 7'd0, 16'd0, 8'h00, 8'h00, 1'b0), 1'b1,
                         mk_result(ST_ARB, STOP_CANCEL, 16'd2, 16'd0, 16'd1, 16'd1)});
    dir_rows.push_back('{mk_event(CMD_NACK, 7'd127, 16'hFFFF, 8'hFF, 8'hFF, 1'b1), 1'b1,
                         mk_result(ST_NACK, STOP_REQ, 16'd3, 16'd1, 16'd1, 16'd1)});
    dir_rows.push_back('{mk_event(CMD_BYTE_RX, 7'd0, 16'd0, 8'hFF, 8'h00, 1'b0), 1'b1,
                         mk_result(ST_NACK, STOP_REQ, 16'd3, 16'd1, 16'd1, 16'd1)});
    dir_rows.push_back('{mk_event(CMD_TX_READY, 7'd0, 16'd0, 8'h00, 8'hFF, 1'b0), 1'b0, '0});
    // Short read on a busy bus, stored bytes at both data extremes.
    dir_rows.push_back('{mk_event(CMD_START_READ, 7'd127, 16'd0, 8'h00, 8'h00, 1'b1),
                         1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_BYTE_RX, 7'd0, 16'd0, 8'hFF, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_BYTE_RX, 7'd0, 16'd0, 8'h00, 8'hFF, 1'b0), 1'b0, '0});
    // Empty write, then a two-byte write.
    dir_rows.push_back('{mk_event(CMD_START_WRITE, 7'd0, 16'd0, 8'h00, 8'h00, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_TX_READY, 7'd0, 16'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_START_WRITE, 7'h55, 16'd2, 8'h00, 8'h00, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_TX_READY, 7'd0, 16'd0, 8'h00, 8'hFF, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_TX_READY, 7'd0, 16'd0, 8'hFF, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_TX_READY, 7'd0, 16'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    // A read abandoned by a new write, which then sees a NACK.
    dir_rows.push_back('{mk_event(CMD_START_READ, 7'h2A, 16'd3, 8'h00, 8'h00, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_BYTE_RX, 7'd0, 16'd0, 8'hA5, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_START_WRITE, 7'h15, 16'd1, 8'h00, 8'h00, 1'b1),
                         1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_TX_READY, 7'd0, 16'd0, 8'h00, 8'h5A, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_NACK, 7'd0, 16'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    // Failed reads: arbitration loss and NACK both ask for recovery.
    dir_rows.push_back('{mk_event(CMD_START_READ, 7'h01, 16'd1, 8'h00, 8'h00, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_ARB_LOST, 7'd0, 16'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_START_READ, 7'h40, 16'hFFFF, 8'h00, 8'h00, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_NACK, 7'd0, 16'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_event(CMD_TICK, 7'd0, 16'd0, 8'h00, 8'h00, 1'b0), 1'b0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) drive_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);

    long_stall_req = 1'b1;
    random_transfers(400);

    wait_drained();
    write_timeout(16'd1);
    random_transfers(300);

    wait_drained();
    write_timeout(16'($urandom_range(2, 6)));
    random_transfers(300);

    // Longest timeout: transfers here never run out of ticks.
    wait_drained();
    write_timeout(16'hFFFF);
    random_transfers(250);

    wait_drained();
    write_timeout(16'($urandom_range(7, 64)));
    random_transfers(300);

    wait_drained();
    write_timeout(16'($urandom_range(1, 65535)));
    random_transfers(200);

    wait_drained();
    $display("Checked %0d result beats from %0d events over %0d timeout settings.",
             beats_checked, events_sent, timeout_writes + 1);
    $display("Covered reads, writes, aborts, stray events and timeouts up to the longest one.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
